>>> hdl/cbm_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the cartridge bank mapper.
// Used by cbm_regs, cbm_decode, the top level and the checker; no dependencies.
package cbm_pkg;

    // Access kinds on the input channel
    localparam logic [1:0] REQ_PRG_READ  = 2'd0;
    localparam logic [1:0] REQ_PRG_WRITE = 2'd1;
    localparam logic [1:0] REQ_CHR_READ  = 2'd2;
    localparam logic [1:0] REQ_CHR_WRITE = 2'd3;

    // Target memory codes on the result channel
    localparam logic [2:0] TGT_NONE      = 3'd0;
    localparam logic [2:0] TGT_PRG_ROM   = 3'd1;
    localparam logic [2:0] TGT_PRG_RAM   = 3'd2;
    localparam logic [2:0] TGT_CHR_ROM   = 3'd3;
    localparam logic [2:0] TGT_CHR_RAM   = 3'd4;
    localparam logic [2:0] TGT_NAMETABLE = 3'd5;
    localparam logic [2:0] TGT_REGISTER  = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] CFG_A0_POS    = 3'd0;
    localparam logic [2:0] CFG_A1_POS    = 3'd1;
    localparam logic [2:0] CFG_PRG_BANKS = 3'd2;
    localparam logic [2:0] CFG_PRG_RAM   = 3'd3;
    localparam logic [2:0] CFG_CHR_ROM   = 3'd4;
    localparam logic [2:0] CFG_CHR_RAM   = 3'd5;

    // Mirror modes
    localparam logic [1:0] MIR_VERTICAL   = 2'd0;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
    localparam logic [1:0] MIR_SINGLE_LO  = 2'd2;
    localparam logic [1:0] MIR_SINGLE_HI  = 2'd3;

    localparam int MAP_W = 18;

    typedef struct packed {
        logic [2:0] a0_pos;
        logic [2:0] a1_pos;
        logic [5:0] prg_banks;
        logic       prg_ram;
        logic       chr_rom;
        logic       chr_ram;
    } cfg_t;

    typedef struct packed {
        logic [1:0][4:0] prg_bank;
        logic [7:0][7:0] chr_bank;
        logic [1:0]      mirror;
        logic            latch;
    } bank_state_t;

    // State changes requested by one access
    typedef struct packed {
        logic       prg0_we;
        logic       prg1_we;
        logic       mirror_we;
        logic       chr_we;
        logic [2:0] chr_idx;
        logic       chr_hi;
        logic       latch_we;
        logic [7:0] data;
    } bank_upd_t;

    typedef struct packed {
        logic [2:0]       target;
        logic [MAP_W-1:0] mapped_address;
        logic [7:0]       read_data;
    } result_t;

endpackage

>>> hdl/cbm_regs.sv
`timescale 1ns / 1ps
// Configuration registers and bank-switching state of the mapper.
// Depends on cbm_pkg.
module cbm_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                commit,
    input  cbm_pkg::bank_upd_t  upd,
    output cbm_pkg::cfg_t        cfg,
    output cbm_pkg::bank_state_t bank
);

    cbm_pkg::cfg_t        cfg_reg;
    cbm_pkg::bank_state_t bank_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.a0_pos    <= 3'd0;
            cfg_reg.a1_pos    <= 3'd1;
            cfg_reg.prg_banks <= 6'd32;
            cfg_reg.prg_ram   <= 1'b0;
            cfg_reg.chr_rom   <= 1'b1;
            cfg_reg.chr_ram   <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                cbm_pkg::CFG_A0_POS:    cfg_reg.a0_pos    <= cfg_data[2:0];
                cbm_pkg::CFG_A1_POS:    cfg_reg.a1_pos    <= cfg_data[2:0];
                cbm_pkg::CFG_PRG_BANKS: cfg_reg.prg_banks <= cfg_data[5:0];
                cbm_pkg::CFG_PRG_RAM:   cfg_reg.prg_ram   <= cfg_data[0];
                cbm_pkg::CFG_CHR_ROM:   cfg_reg.chr_rom   <= cfg_data[0];
                cbm_pkg::CFG_CHR_RAM:   cfg_reg.chr_ram   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg <= '0;
        end else if (commit) begin
            if (upd.prg0_we)   bank_reg.prg_bank[0] <= upd.data[4:0];
            if (upd.prg1_we)   bank_reg.prg_bank[1] <= upd.data[4:0];
            if (upd.mirror_we) bank_reg.mirror      <= upd.data[1:0];
            if (upd.latch_we)  bank_reg.latch       <= upd.data[0];
            if (upd.chr_we) begin
                if (upd.chr_hi) begin
                    bank_reg.chr_bank[upd.chr_idx][7:4] <= upd.data[3:0];
                end else begin
                    bank_reg.chr_bank[upd.chr_idx][3:0] <= upd.data[3:0];
                end
            end
        end
    end

    assign cfg  = cfg_reg;
    assign bank = bank_reg;

endmodule

>>> hdl/cbm_decode.sv
`timescale 1ns / 1ps
// Address decode for one bus access: target, mapped address, read data and
// the register updates a write causes. Purely combinational; depends on cbm_pkg.
module cbm_decode #(
    parameter int PRG_RAM_ADDR_BITS = 13
) (
    input  logic [1:0]           req_type,
    input  logic [15:0]          address,
    input  logic [7:0]           bus_data,
    input  cbm_pkg::cfg_t        cfg,
    input  cbm_pkg::bank_state_t bank,
    output cbm_pkg::result_t     res,
    output cbm_pkg::bank_upd_t   upd
);

    logic       is_write;
    logic       sel0;
    logic       sel1;
    logic [3:0] group;
    logic [3:0] group_off;
    logic [4:0] prg_sel;
    logic [7:0] chr_sel;
    logic [10:0] nt_addr;

    assign is_write  = req_type[0];
    assign sel0      = address[cfg.a0_pos];
    assign sel1      = address[cfg.a1_pos];
    assign group     = address[15:12];
    assign group_off = group - 4'hB;
    assign chr_sel   = bank.chr_bank[address[12:10]];

    always_comb begin
        case (address[14:13])
            2'd0:    prg_sel = bank.prg_bank[0];
            2'd1:    prg_sel = bank.prg_bank[1];
            2'd2:    prg_sel = 5'(cfg.prg_banks - 6'd2);
            default: prg_sel = 5'(cfg.prg_banks - 6'd1);
        endcase
    end

    always_comb begin
        case (bank.mirror)
            cbm_pkg::MIR_VERTICAL:   nt_addr = {address[10], address[9:0]};
            cbm_pkg::MIR_HORIZONTAL: nt_addr = {address[11], address[9:0]};
            cbm_pkg::MIR_SINGLE_LO:  nt_addr = {1'b0, address[9:0]};
            default:                 nt_addr = {1'b1, address[9:0]};
        endcase
    end

    always_comb begin
        res = '0;
        upd = '0;
        upd.data    = bus_data;
        upd.chr_idx = {group_off[1:0], sel1};
        upd.chr_hi  = sel0;
        if (!req_type[1]) begin
            if (address < 16'h6000) begin
                if (!is_write) res.read_data = bus_data;
            end else if (!address[15]) begin
                if (cfg.prg_ram) begin
                    res.target         = cbm_pkg::TGT_PRG_RAM;
                    res.mapped_address = cbm_pkg::MAP_W'(address[PRG_RAM_ADDR_BITS-1:0]);
                end else if (group == 4'h6) begin
                    // one-bit latch in place of save RAM
                    res.target = cbm_pkg::TGT_REGISTER;
                    if (is_write) upd.latch_we = 1'b1;
                    else          res.read_data = {bus_data[7:1], bus_data[0] | bank.latch};
                end else if (!is_write) begin
                    res.read_data = bus_data;
                end
            end else if (is_write) begin
                res.target = cbm_pkg::TGT_REGISTER;
                case (group)
                    4'h8:    upd.prg0_we   = 1'b1;
                    4'h9:    upd.mirror_we = 1'b1;
                    4'hA:    upd.prg1_we   = 1'b1;
                    4'hB, 4'hC, 4'hD, 4'hE: upd.chr_we = 1'b1;
                    default: ;
                endcase
            end else begin
                res.target         = cbm_pkg::TGT_PRG_ROM;
                res.mapped_address = {prg_sel, address[12:0]};
            end
        end else begin
            if (address[13]) begin
                res.target         = cbm_pkg::TGT_NAMETABLE;
                res.mapped_address = cbm_pkg::MAP_W'(nt_addr);
            end else if (!is_write) begin
                if (cfg.chr_rom) begin
                    res.target         = cbm_pkg::TGT_CHR_ROM;
                    res.mapped_address = {chr_sel, address[9:0]};
                end else if (cfg.chr_ram) begin
                    res.target         = cbm_pkg::TGT_CHR_RAM;
                    res.mapped_address = {chr_sel, address[9:0]};
                end else begin
                    res.read_data = bus_data;
                end
            end else if (cfg.chr_ram) begin
                res.target         = cbm_pkg::TGT_CHR_RAM;
                res.mapped_address = {chr_sel, address[9:0]};
            end
        end
    end

endmodule

>>> hdl/cartridge_bank_mapper_core.sv
`timescale 1ns / 1ps
// Cartridge bank-switching mapper core. Depends on cbm_pkg, cbm_regs, cbm_decode.
//
// Usage:
//   s_ channel: one CPU program-space or PPU pattern/nametable access per transaction.
//     s_tuser carries the access kind, s_tdata the address and bus data.
//   m_ channel: exactly one result per access, in order: the target memory in
//     m_tuser, mapped address and read data in m_tdata.
//   cfg_ channel: register index and data, always ready; write it only while
//     no access is in flight.
// Timing: an access is held in the input register, is decoded by a single
//   level of logic against the current bank registers and lands in the output
//   register; one access is taken every cycle while m_tready is high.
//   Bank and latch updates take effect at the same edge that registers the
//   result, so the next access already sees them.
// Reset (aresetn low, synchronous): both stages empty, bank state zero,
//   configuration back to its defaults.
// Stall: while m_tready is low the result holds and one more access can wait
//   in the input register; s_tready drops only when both stages are full.
module cartridge_bank_mapper_core #(
    parameter int PRG_RAM_ADDR_BITS = 13
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] bus_data
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [17:0] mapped_address, [25:18] read_data, zero above
    output logic [2:0]  m_tuser,   // [2:0] target
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic                 in_valid_reg;
    logic [1:0]           in_req_reg;
    logic [15:0]          in_addr_reg;
    logic [7:0]           in_data_reg;
    logic                 out_valid_reg;
    cbm_pkg::result_t     out_res_reg;
    logic                 advance;
    logic                 commit;
    cbm_pkg::cfg_t        cfg;
    cbm_pkg::bank_state_t bank;
    cbm_pkg::result_t     res_next;
    cbm_pkg::bank_upd_t   upd;

    assign advance   = !out_valid_reg || m_tready;
    assign commit    = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg  <= s_tuser;
            in_addr_reg <= s_tdata[15:0];
            in_data_reg <= s_tdata[23:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) out_res_reg <= res_next;
    end

    cbm_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .commit    (commit),
        .upd       (upd),
        .cfg       (cfg),
        .bank      (bank)
    );

    cbm_decode #(
        .PRG_RAM_ADDR_BITS (PRG_RAM_ADDR_BITS)
    ) u_decode (
        .req_type (in_req_reg),
        .address  (in_addr_reg),
        .bus_data (in_data_reg),
        .cfg      (cfg),
        .bank     (bank),
        .res      (res_next),
        .upd      (upd)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.target;
    assign m_tdata  = {6'd0, out_res_reg.read_data, out_res_reg.mapped_address};

endmodule

>>> hdl/cbm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the mapper core, bound to the top level.
// Depends on cbm_pkg.
module cbm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Read data only for open-bus and latch answers
    a_read_data_src: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[25:18] != 8'd0) |->
            (m_tuser == cbm_pkg::TGT_NONE) || (m_tuser == cbm_pkg::TGT_REGISTER))
        else $error("read data on a memory target");

    a_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == cbm_pkg::TGT_NONE) || (m_tuser == cbm_pkg::TGT_REGISTER))
            |-> m_tdata[17:0] == 18'd0)
        else $error("mapped address without a memory target");

    // Nametable RAM is 2 KB; save RAM at most 8 KB
    a_small_targets: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == cbm_pkg::TGT_NAMETABLE && m_tdata[17:11] != 7'd0) ||
                     (m_tuser == cbm_pkg::TGT_PRG_RAM && m_tdata[17:13] != 5'd0)) |-> 1'b0)
        else $error("mapped address out of target range");

endmodule

bind cartridge_bank_mapper_core cbm_checker u_cbm_checker (.*);
